// ===== hdl/tlvd_pkg.sv =====
// Shared types and constants for the TLV record deframer.
`timescale 1ns / 1ps

package tlvd_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int LEN_W = 16;

	// Length byte escapes
	localparam logic [7:0] LEN_LONG1 = 8'h81;
	localparam logic [7:0] LEN_LONG2 = 8'h82;

	// Result kinds
	localparam logic [1:0] KIND_VALUE     = 2'd0;
	localparam logic [1:0] KIND_EMPTY     = 2'd1;
	localparam logic [1:0] KIND_TRUNC_HDR = 2'd2;
	localparam logic [1:0] KIND_TRUNC_VAL = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       value_byte;
		logic [7:0]       record_tag;
		logic             last_of_record;
		logic [LEN_W-1:0] record_length;
	} rec_t;

endpackage

// ===== hdl/tlv_record_deframer_unit.sv =====
// Top level of the TLV record deframer.
`timescale 1ns / 1ps

// Splits a byte stream into tag-length-value records.
// Slave side: one buffer byte per beat on s_tdata, s_tlast on the final
// byte of the buffer. Each record is a tag byte, a length byte (0x81 and
// 0x82 escape to one or two big-endian length bytes), then the value.
// Master side: one result beat per value byte, or one beat for an empty
// record or a truncated record. m_tuser carries the result kind, m_tlast
// marks the final beat of a record (also on every truncation result).
// Tag and length bytes normally give no result beat.
// Throughput: one input beat per cycle while the queue is not full; the
// parser is a phase register, tag and length registers and a LENGTH_BITS
// down-counter, updated on every accepted beat. Each result is written into
// the queue when its input beat is taken and is presented from the queue head.
// Results sit in a QUEUE_DEPTH-entry queue; when the receiver stalls the
// queue fills and s_tready drops only once it is full, so the parser keeps
// taking beats until then.
// Reset (arst_n low) returns the parser to waiting for a tag, clears the
// held tag and length, and empties the queue.
module tlv_record_deframer_unit #(
	parameter int LENGTH_BITS = tlvd_pkg::LENGTH_BITS_DEF,
	parameter int QUEUE_DEPTH = tlvd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_in
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] value_byte, [15:8] record_tag, [31:16] record_length
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last_of_record
);

	logic           push;
	logic           q_not_full;
	tlvd_pkg::rec_t f_rec;
	tlvd_pkg::rec_t q_rec;

	// front: header parse and byte classification
	tlvd_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (s_tvalid),
		.beat_data  (s_tdata),
		.beat_last  (s_tlast),
		.queue_ready(q_not_full),
		.push       (push),
		.rec        (f_rec)
	);

	// queue decouples parser from receiver stalls
	tlvd_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (f_rec),
		.not_full (q_not_full),
		.pop_valid(m_tvalid),
		.pop_ready(m_tready),
		.pop_rec  (q_rec)
	);

	assign s_tready = q_not_full;
	assign m_tdata  = {q_rec.record_length, q_rec.record_tag, q_rec.value_byte};
	assign m_tuser  = q_rec.kind;
	assign m_tlast  = q_rec.last_of_record;

endmodule

// ===== hdl/tlvd_front.sv =====
// Front end: header parser and value byte classifier.
`timescale 1ns / 1ps

module tlvd_front #(
	parameter int LENGTH_BITS = tlvd_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              beat_valid,
	input  logic [7:0]        beat_data,
	input  logic              beat_last,
	input  logic              queue_ready,
	output logic              push,
	output tlvd_pkg::rec_t    rec
);

	localparam int LB = LENGTH_BITS;

	typedef enum logic [5:0] {
		PH_TAG   = 6'b000001,
		PH_LEN   = 6'b000010,
		PH_LEN1  = 6'b000100,
		PH_HI    = 6'b001000,
		PH_LO    = 6'b010000,
		PH_VALUE = 6'b100000
	} phase_t;

	phase_t          ph_q, ph_d;
	logic [7:0]      tag_q, tag_d;
	logic [LB-1:0]   len_q, len_d;
	logic [LB-1:0]   rem_q, rem_d, rem_dec;
	logic [15:0]     b16, hi16;
	logic            accept, done, cut, clr, emit;
	logic [1:0]      kind;
	logic [7:0]      vb;
	logic            last;

	assign accept  = beat_valid & queue_ready;
	assign b16     = {8'h00, beat_data};
	assign hi16    = {beat_data, 8'h00};
	assign rem_dec = rem_q - {{(LB-1){1'b0}}, 1'b1};

	always_comb begin
		ph_d  = ph_q;
		tag_d = tag_q;
		len_d = len_q;
		rem_d = rem_q;
		done  = 1'b0;
		cut   = 1'b0;
		clr   = 1'b0;
		emit  = 1'b0;
		kind  = tlvd_pkg::KIND_VALUE;
		vb    = 8'h00;
		last  = 1'b0;
		unique case (ph_q)
			PH_TAG: begin
				tag_d = beat_data;
				len_d = '0;
				rem_d = '0;
				ph_d  = PH_LEN;
				cut   = beat_last;
			end
			PH_LEN: begin
				if (beat_data == tlvd_pkg::LEN_LONG2) begin
					ph_d = PH_HI;
					cut  = beat_last;
				end else if (beat_data == tlvd_pkg::LEN_LONG1) begin
					ph_d = PH_LEN1;
					cut  = beat_last;
				end else begin
					len_d = b16[LB-1:0];
					done  = 1'b1;
				end
			end
			PH_LEN1: begin
				len_d = b16[LB-1:0];
				done  = 1'b1;
			end
			PH_HI: begin
				len_d = hi16[LB-1:0];
				ph_d  = PH_LO;
				cut   = beat_last;
			end
			PH_LO: begin
				len_d = len_q | b16[LB-1:0];
				done  = 1'b1;
			end
			PH_VALUE: begin
				rem_d = rem_dec;
				emit  = 1'b1;
				vb    = beat_data;
				if (rem_dec == '0) begin
					last = 1'b1;
					clr  = 1'b1;
				end else if (beat_last) begin
					kind = tlvd_pkg::KIND_TRUNC_VAL;
					last = 1'b1;
					clr  = 1'b1;
				end
			end
			default: begin
				clr = 1'b1;
			end
		endcase
		// length complete: open the value or close the record
		if (done) begin
			if (len_d == '0) begin
				emit = 1'b1;
				kind = tlvd_pkg::KIND_EMPTY;
				last = 1'b1;
				clr  = 1'b1;
			end else if (beat_last) begin
				emit = 1'b1;
				kind = tlvd_pkg::KIND_TRUNC_HDR;
				last = 1'b1;
				clr  = 1'b1;
			end else begin
				rem_d = len_d;
				ph_d  = PH_VALUE;
			end
		end
		if (cut) begin
			emit = 1'b1;
			kind = tlvd_pkg::KIND_TRUNC_HDR;
			last = 1'b1;
			clr  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_TAG;
			tag_q <= 8'h00;
			len_q <= '0;
			rem_q <= '0;
		end else if (accept) begin
			tag_q <= tag_d;
			if (clr) begin
				ph_q  <= PH_TAG;
				len_q <= '0;
				rem_q <= '0;
			end else begin
				ph_q  <= ph_d;
				len_q <= len_d;
				rem_q <= rem_d;
			end
		end
	end

	assign push               = accept & emit;
	assign rec.kind           = kind;
	assign rec.value_byte     = vb;
	assign rec.record_tag     = tag_d;
	assign rec.last_of_record = last;
	assign rec.record_length  = tlvd_pkg::LEN_W'(len_d);

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_VALUE) |-> (rem_q != '0))
		else $error("value phase with no bytes remaining");
	a_tag_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_TAG) |-> (len_q == '0 && rem_q == '0))
		else $error("stale length at tag phase");
	a_end_to_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && beat_last) |=> (ph_q == PH_TAG))
		else $error("frame end did not return to tag phase");
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push && rec.kind != tlvd_pkg::KIND_VALUE) |-> rec.last_of_record)
		else $error("non-value result without record end");

endmodule

// ===== hdl/tlvd_fifo.sv =====
// Result queue between the parser front end and the output side.
`timescale 1ns / 1ps

module tlvd_fifo #(
	parameter int DEPTH = tlvd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tlvd_pkg::rec_t  push_rec,
	output logic            not_full,
	output logic            pop_valid,
	input  logic            pop_ready,
	output tlvd_pkg::rec_t  pop_rec
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	tlvd_pkg::rec_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	assign not_full  = (cnt_q != FULL_CNT);
	assign pop_valid = (cnt_q != '0);
	assign pop       = pop_valid & pop_ready;
	assign pop_rec   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full)
		else $error("push into full queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count out of range");
	a_held_head: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && !pop_ready) |=> (pop_valid && $stable(rd_q)))
		else $error("queue head moved while stalled");

endmodule

// ===== tb/tlv_record_deframer_unit_tb.sv =====
// Self-checking testbench for the TLV record deframer: directed records, then random streams.
`timescale 1ns / 1ps

module tlv_record_deframer_unit_tb;

	localparam int DIRECTED_ROWS = 23;
	localparam int RANDOM_BYTES = 600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int LONG_HOLD_AT = 150;
	localparam logic [15:0] LEN_MASK = 16'((32'd1 << tlvd_pkg::LENGTH_BITS_DEF) - 1);

	// Parser phases of the model
	typedef enum logic [2:0] {
		PH_TAG, PH_LEN, PH_LEN1, PH_HI, PH_LO, PH_VALUE
	} parse_phase_t;

	// One input byte; when pinned is set the result is given here, not by the model
	typedef struct packed {
		logic [7:0]  data;
		logic        fend;
		logic        pinned;
		logic [1:0]  kind;
		logic [7:0]  vbyte;
		logic [7:0]  tag;
		logic        last;
		logic [15:0] len;
	} stim_byte_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] byte_in
	logic        s_tlast;   // frame_end
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [7:0] value_byte, [15:8] record_tag, [31:16] record_length
	logic [1:0]  m_tuser;   // [1:0] kind
	logic        m_tlast;   // last_of_record

	tlv_record_deframer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Parser state as seen by the predictor
	parse_phase_t phase_q;
	logic [7:0]   tag_q;
	logic [15:0]  len_q;
	logic [15:0]  remain_q;

	stim_byte_t     directed_rows [DIRECTED_ROWS];
	stim_byte_t     byte_stream_q [$];
	tlvd_pkg::rec_t expected_recs [$];
	int             mismatches = 0;
	int             recs_checked = 0;
	int             cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[tlv_record_deframer_unit] ERROR");
			$finish;
		end
	end

	function automatic tlvd_pkg::rec_t make_rec(logic [1:0] kind, logic [7:0] vbyte, logic last);
		tlvd_pkg::rec_t r;
		r.kind = kind;
		r.value_byte = vbyte;
		r.record_tag = tag_q;
		r.last_of_record = last;
		r.record_length = len_q;
		return r;
	endfunction

	function automatic void drop_record();
		phase_q = PH_TAG;
		len_q = '0;
		remain_q = '0;
	endfunction

	// Length fully decoded: empty record, cut header, or start of the value
	function automatic bit length_complete(bit fend, output tlvd_pkg::rec_t r);
		r = '0;
		if (len_q == '0) begin
			r = make_rec(tlvd_pkg::KIND_EMPTY, 8'h00, 1'b1);
			drop_record();
			return 1'b1;
		end
		if (fend) begin
			r = make_rec(tlvd_pkg::KIND_TRUNC_HDR, 8'h00, 1'b1);
			drop_record();
			return 1'b1;
		end
		remain_q = len_q;
		phase_q = PH_VALUE;
		return 1'b0;
	endfunction

	// Header still incomplete: frame end cuts it, otherwise nothing comes out
	function automatic bit header_byte(bit fend, output tlvd_pkg::rec_t r);
		r = '0;
		if (!fend)
			return 1'b0;
		r = make_rec(tlvd_pkg::KIND_TRUNC_HDR, 8'h00, 1'b1);
		drop_record();
		return 1'b1;
	endfunction

	// Advances the parser by one byte; returns 1 when a result beat is due
	function automatic bit deframe_byte(logic [7:0] b, bit fend, output tlvd_pkg::rec_t r);
		r = '0;
		case (phase_q)
			PH_TAG: begin
				tag_q = b;
				len_q = '0;
				remain_q = '0;
				phase_q = PH_LEN;
				return header_byte(fend, r);
			end
			PH_LEN: begin
				if (b == tlvd_pkg::LEN_LONG2) begin
					phase_q = PH_HI;
					return header_byte(fend, r);
				end
				if (b == tlvd_pkg::LEN_LONG1) begin
					phase_q = PH_LEN1;
					return header_byte(fend, r);
				end
				len_q = {8'h00, b} & LEN_MASK;
				return length_complete(fend, r);
			end
			PH_LEN1: begin
				len_q = {8'h00, b} & LEN_MASK;
				return length_complete(fend, r);
			end
			PH_HI: begin
				len_q = {b, 8'h00} & LEN_MASK;
				phase_q = PH_LO;
				return header_byte(fend, r);
			end
			PH_LO: begin
				len_q = (len_q | {8'h00, b}) & LEN_MASK;
				return length_complete(fend, r);
			end
			PH_VALUE: begin
				remain_q = remain_q - 16'd1;
				if (remain_q == '0) begin
					r = make_rec(tlvd_pkg::KIND_VALUE, b, 1'b1);
					drop_record();
				end else if (fend) begin
					r = make_rec(tlvd_pkg::KIND_TRUNC_VAL, b, 1'b1);
					drop_record();
				end else begin
					r = make_rec(tlvd_pkg::KIND_VALUE, b, 1'b0);
				end
				return 1'b1;
			end
			default: begin
				drop_record();
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void push_byte(logic [7:0] data, logic fend);
		stim_byte_t sb;
		sb = '0;
		sb.data = data;
		sb.fend = fend;
		byte_stream_q.insert(byte_stream_q.size(), sb);
	endfunction

	// Random part: mostly well-formed records, some cut short, some noise bursts
	function automatic void build_random_stream();
		logic [7:0]  hdr [$];
		logic [7:0]  lb;
		logic [7:0]  hi;
		logic [7:0]  lo;
		int unsigned len;
		int unsigned total;
		int unsigned lim;
		int          cut;
		int          n;
		while (byte_stream_q.size() < DIRECTED_ROWS + RANDOM_BYTES) begin
			if ($urandom_range(0, 99) < 8) begin
				// noise burst, closed by a frame end so the next record starts clean
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 3) == 0));
			end else begin
				hdr.delete();
				hdr.insert(hdr.size(), 8'($urandom));
				case ($urandom_range(0, 9))
					6: begin
						lb = 8'($urandom);
						if (lb == tlvd_pkg::LEN_LONG1 || lb == tlvd_pkg::LEN_LONG2)
							lb = 8'h7f;
						hdr.insert(hdr.size(), lb);
						len = 32'(lb);
					end
					7: begin
						lb = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
						hdr.insert(hdr.size(), tlvd_pkg::LEN_LONG1);
						hdr.insert(hdr.size(), lb);
						len = 32'(lb);
					end
					8, 9: begin
						if ($urandom_range(0, 3) == 0) begin
							hi = 8'($urandom);
							lo = 8'($urandom);
						end else begin
							hi = 8'h00;
							lo = 8'($urandom_range(0, 12));
						end
						hdr.insert(hdr.size(), tlvd_pkg::LEN_LONG2);
						hdr.insert(hdr.size(), hi);
						hdr.insert(hdr.size(), lo);
						len = 32'({hi, lo});
					end
					default: begin
						lb = 8'($urandom_range(0, 8));
						hdr.insert(hdr.size(), lb);
						len = 32'(lb);
					end
				endcase
				total = hdr.size() + len;
				cut = -1;
				// long records are always cut early to keep the run short
				if (len > 48 || $urandom_range(0, 9) == 0) begin
					lim = (total - 1 < hdr.size() + 47) ? total - 1 : hdr.size() + 47;
					cut = $urandom_range(0, lim);
				end
				for (int i = 0; i < total; i++) begin
					push_byte((i < hdr.size()) ? hdr[i] : 8'($urandom),
						(i == cut) || (cut < 0 && i == total - 1 && $urandom_range(0, 3) == 0));
					if (i == cut)
						break;
				end
			end
		end
	endfunction

	// Compares one accepted result beat with the oldest expectation
	function automatic void check_result();
		tlvd_pkg::rec_t got;
		tlvd_pkg::rec_t want;
		got.kind = m_tuser;
		got.value_byte = m_tdata[7:0];
		got.record_tag = m_tdata[15:8];
		got.last_of_record = m_tlast;
		got.record_length = m_tdata[31:16];
		recs_checked++;
		if (expected_recs.size() == 0) begin
			$display("%0t: result beat with nothing expected: actual %h", $time, got);
			mismatches++;
			return;
		end
		want = expected_recs.pop_front();
		if (got.kind !== want.kind) begin
			$display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
			mismatches++;
		end
		if (got.value_byte !== want.value_byte) begin
			$display("%0t: value_byte expected %h actual %h", $time,
				want.value_byte, got.value_byte);
			mismatches++;
		end
		if (got.record_tag !== want.record_tag) begin
			$display("%0t: record_tag expected %h actual %h", $time,
				want.record_tag, got.record_tag);
			mismatches++;
		end
		if (got.last_of_record !== want.last_of_record) begin
			$display("%0t: last_of_record expected %0d actual %0d", $time,
				want.last_of_record, got.last_of_record);
			mismatches++;
		end
		if (got.record_length !== want.record_length) begin
			$display("%0t: record_length expected %h actual %h", $time,
				want.record_length, got.record_length);
			mismatches++;
		end
	endfunction

	// Result side: random stalls, bursts without stalls, one long hold-off
	initial begin : result_sink
		int stall;
		bit burst;
		bit held;
		burst = 1'b0;
		held = 1'b0;
		m_tready = 1'b0;
		forever begin
			stall = burst ? 0 : $urandom_range(0, 14);
			if ($urandom_range(0, 39) == 0)
				burst = !burst;
			// long hold-off lets the result queue fill so s_tready has to drop
			if (!held && recs_checked == LONG_HOLD_AT) begin
				stall = LONG_HOLD_CYCLES;
				held = 1'b1;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_result();
		end
	end

	// Byte side: directed rows, random stream, then drain and report
	initial begin : byte_source
		stim_byte_t     sb;
		tlvd_pkg::rec_t r;
		bit             hit;
		bit             burst;
		int             gap;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		burst = 1'b0;
		phase_q = PH_TAG;
		tag_q = '0;
		len_q = '0;
		remain_q = '0;

		// data, fend, pinned, kind, value_byte, tag, last, length
		directed_rows = '{
			// frame end on the tag byte
			'{8'ha5, 1'b1, 1'b1, tlvd_pkg::KIND_TRUNC_HDR, 8'h00, 8'ha5, 1'b1, 16'h0000},
			// empty record, tag zero
			'{8'h00, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'h00, 1'b0, 1'b1, tlvd_pkg::KIND_EMPTY,     8'h00, 8'h00, 1'b1, 16'h0000},
			// one-byte record, all ones
			'{8'hff, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'h01, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'hff, 1'b0, 1'b1, tlvd_pkg::KIND_VALUE,     8'hff, 8'hff, 1'b1, 16'h0001},
			// two-byte length, last value byte also ends the frame
			'{8'h22, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{tlvd_pkg::LEN_LONG2, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,
				8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'h00, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'h01, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'h7f, 1'b1, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			// frame ends between the two length bytes
			'{8'h33, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{tlvd_pkg::LEN_LONG2, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,
				8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'hff, 1'b1, 1'b1, tlvd_pkg::KIND_TRUNC_HDR, 8'h00, 8'h33, 1'b1, 16'hff00},
			// frame ends right after a nonzero length
			'{8'h45, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'h05, 1'b1, 1'b1, tlvd_pkg::KIND_TRUNC_HDR, 8'h00, 8'h45, 1'b1, 16'h0005},
			// frame ends inside the value
			'{8'h46, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'h03, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'h12, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'h34, 1'b1, 1'b1, tlvd_pkg::KIND_TRUNC_VAL, 8'h34, 8'h46, 1'b1, 16'h0003},
			// one-byte escape to a zero length at the frame end
			'{8'h47, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,     8'h00, 8'h00, 1'b0, 16'h0000},
			'{tlvd_pkg::LEN_LONG1, 1'b0, 1'b0, tlvd_pkg::KIND_VALUE,
				8'h00, 8'h00, 1'b0, 16'h0000},
			'{8'h00, 1'b1, 1'b1, tlvd_pkg::KIND_EMPTY,     8'h00, 8'h47, 1'b1, 16'h0000}
		};
		foreach (directed_rows[i])
			byte_stream_q.insert(byte_stream_q.size(), directed_rows[i]);
		build_random_stream();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < byte_stream_q.size(); i++) begin
			sb = byte_stream_q[i];
			gap = burst ? 0 : $urandom_range(0, 14);
			if ($urandom_range(0, 39) == 0)
				burst = !burst;
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= sb.data;
			s_tlast <= sb.fend;
			do @(posedge clk); while (!s_tready);
			// beat taken: predictor always advances, pinned rows override its result
			hit = deframe_byte(sb.data, sb.fend, r);
			if (sb.pinned)
				expected_recs.insert(expected_recs.size(),
					{sb.kind, sb.vbyte, sb.tag, sb.last, sb.len});
			else if (hit)
				expected_recs.insert(expected_recs.size(), r);
		end
		s_tvalid <= 1'b0;

		while (expected_recs.size() != 0)
			@(posedge clk);
		// then keep clocking to catch a stray beat from the result queue
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("[tlv_record_deframer_unit] OK");
		else
			$display("[tlv_record_deframer_unit] ERROR");
		$finish;
	end

endmodule
